@@ rtl/speech_endpoint_detector_macros.svh @@
// Assertion macros for the speech endpoint detector checker.
// Expect signals clk and rst_n in the scope of use.
`ifndef SPEECH_ENDPOINT_DETECTOR_MACROS_SVH
`define SPEECH_ENDPOINT_DETECTOR_MACROS_SVH

// same-cycle implication
`define SED_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sed check failed");

// next-cycle implication
`define SED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sed check failed");

`endif

@@ rtl/sed_pkg.sv @@
// Shared types and constants for the speech endpoint detector.
// No dependencies.
package sed_pkg;

    localparam int CNT_W = 16;
    localparam int THR_W = 8;
    localparam int EV_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // event codes
    localparam logic [EV_W-1:0] EV_IDLE   = 3'd0;
    localparam logic [EV_W-1:0] EV_LISTEN = 3'd1;
    localparam logic [EV_W-1:0] EV_START  = 3'd2;
    localparam logic [EV_W-1:0] EV_ACCEPT = 3'd3;
    localparam logic [EV_W-1:0] EV_REJECT = 3'd4;

    // command codes
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_ARM   = 1'b1;

    // register indexes
    localparam logic [1:0] REG_VOICE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_QUIET_FRAMES    = 2'd1;
    localparam logic [1:0] REG_MAX_FRAMES      = 2'd2;
    localparam logic [1:0] REG_MIN_VOICED      = 2'd3;

    // reset values
    localparam logic [THR_W-1:0] RST_VOICE_THRESHOLD = 8'd128;
    localparam logic [CNT_W-1:0] RST_QUIET_FRAMES    = 16'd150;
    localparam logic [CNT_W-1:0] RST_MAX_FRAMES      = 16'd3000;
    localparam logic [CNT_W-1:0] RST_MIN_VOICED      = 16'd10;

    // tdata layout of the result: speech_active, silence_run, voiced_total
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [THR_W-1:0] voice_threshold;
        logic [CNT_W-1:0] quiet_frames;
        logic [CNT_W-1:0] max_frames;
        logic [CNT_W-1:0] min_voiced;
    } sed_cfg_t;

    typedef struct packed {
        logic [EV_W-1:0]  event_res;
        logic             speech_active;
        logic [CNT_W-1:0] silence_run;
        logic [CNT_W-1:0] voiced_total;
    } sed_result_t;

endpackage

@@ rtl/sed_cfg_regs.sv @@
// APB-style configuration register bank of the speech endpoint detector.
// Depends on sed_pkg.
module sed_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sed_pkg::sed_cfg_t cfg
);
    import sed_pkg::*;

    sed_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voice_threshold <= RST_VOICE_THRESHOLD;
            cfg_reg.quiet_frames    <= RST_QUIET_FRAMES;
            cfg_reg.max_frames      <= RST_MAX_FRAMES;
            cfg_reg.min_voiced      <= RST_MIN_VOICED;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_VOICE_THRESHOLD: cfg_reg.voice_threshold <= pwdata[THR_W-1:0];
                REG_QUIET_FRAMES:    cfg_reg.quiet_frames    <= pwdata[CNT_W-1:0];
                REG_MAX_FRAMES:      cfg_reg.max_frames      <= pwdata[CNT_W-1:0];
                REG_MIN_VOICED:      cfg_reg.min_voiced      <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_VOICE_THRESHOLD: prdata = {24'd0, cfg_reg.voice_threshold};
            REG_QUIET_FRAMES:    prdata = {16'd0, cfg_reg.quiet_frames};
            REG_MAX_FRAMES:      prdata = {16'd0, cfg_reg.max_frames};
            REG_MIN_VOICED:      prdata = {16'd0, cfg_reg.min_voiced};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/sed_core.sv @@
// Session state and per-frame endpoint decision.
// Depends on sed_pkg.
module sed_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 command,
    input  logic [7:0]           frame_score,
    input  sed_pkg::sed_cfg_t    cfg,
    output sed_pkg::sed_result_t res
);
    import sed_pkg::*;

    logic             armed_reg,  armed_next;
    logic             seen_reg,   seen_next;
    logic [CNT_W-1:0] silence_reg, silence_next;
    logic [CNT_W-1:0] voiced_reg,  voiced_next;
    logic [CNT_W-1:0] frame_reg,   frame_next;
    logic [EV_W-1:0]  ev;
    logic             voiced;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    assign voiced = frame_score >= cfg.voice_threshold;

    always_comb
    begin
        armed_next   = armed_reg;
        seen_next    = seen_reg;
        silence_next = silence_reg;
        voiced_next  = voiced_reg;
        frame_next   = frame_reg;
        ev           = EV_IDLE;
        if (command == CMD_ARM)
        begin
            ev = EV_LISTEN;
            if (!armed_reg)
            begin
                armed_next   = 1'b1;
                seen_next    = 1'b0;
                silence_next = '0;
                voiced_next  = '0;
                frame_next   = '0;
            end
        end
        else if (armed_reg)
        begin
            ev         = EV_LISTEN;
            frame_next = sat_inc(frame_reg);
            if (!seen_reg)
            begin
                if (voiced)
                begin
                    seen_next   = 1'b1;
                    voiced_next = sat_inc(voiced_reg);
                    ev          = EV_START;
                end
                else if (frame_next >= cfg.max_frames)
                begin
                    silence_next = cfg.quiet_frames;
                end
            end
            else
            begin
                if (voiced)
                begin
                    silence_next = '0;
                    voiced_next  = sat_inc(voiced_reg);
                end
                else
                begin
                    silence_next = sat_inc(silence_reg);
                end
                if (frame_next >= cfg.max_frames && silence_next < cfg.quiet_frames)
                begin
                    silence_next = cfg.quiet_frames;
                end
            end
            // end test
            if (silence_next >= cfg.quiet_frames)
            begin
                if (seen_next && voiced_next < cfg.min_voiced)
                begin
                    silence_next = '0;
                    voiced_next  = '0;
                    seen_next    = 1'b0;
                    ev           = EV_REJECT;
                end
                else
                begin
                    armed_next = 1'b0;
                    ev         = EV_ACCEPT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            seen_reg    <= 1'b0;
            silence_reg <= '0;
            voiced_reg  <= '0;
            frame_reg   <= '0;
        end
        else if (step_en)
        begin
            armed_reg   <= armed_next;
            seen_reg    <= seen_next;
            silence_reg <= silence_next;
            voiced_reg  <= voiced_next;
            frame_reg   <= frame_next;
        end
    end

    assign res.event_res     = ev;
    assign res.speech_active = seen_next;
    assign res.silence_run   = silence_next;
    assign res.voiced_total  = voiced_next;

endmodule

@@ rtl/speech_endpoint_detector.sv @@
// Path: input register, then sed_core, then the result register that drives m_*.
// Throughput: one frame or arm command per cycle while m_tready keeps up; each register
// holds one transfer, so an empty input register takes input while a result waits.
// Reset (rst_n, async, active low): session cleared and disarmed, pipeline empty,
// registers back to their reset values.
module speech_endpoint_detector
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_score
    input  logic        s_tuser,   // [0] command
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] speech_active, [16:1] silence_run,
                                   // [32:17] voiced_total, [39:33] zero
    output logic [2:0]  m_tuser,   // [2:0] event_res
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sed_pkg::*;

    sed_cfg_t    cfg;
    sed_result_t res;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_score_reg;
    logic        out_valid_reg;
    sed_result_t out_reg;
    logic        advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    sed_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sed_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (in_valid_reg && advance),
        .command     (in_cmd_reg),
        .frame_score (in_score_reg),
        .cfg         (cfg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser;
            in_score_reg <= s_tdata;
        end
        if (in_valid_reg && advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {7'd0, out_reg.voiced_total, out_reg.silence_run,
                       out_reg.speech_active};

endmodule

@@ rtl/sed_checker.sv @@
// Port-level checker for speech_endpoint_detector, bound to the top level.
// Depends on sed_pkg and speech_endpoint_detector_macros.svh.
`include "speech_endpoint_detector_macros.svh"

module sed_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import sed_pkg::*;

    `SED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `SED_ASSERT_IMP(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready)
    `SED_ASSERT_IMP(a_reject_clears, m_tvalid && m_tuser == EV_REJECT,
        m_tdata[32:0] == 33'd0)
    `SED_ASSERT_IMP(a_start_first_voiced, m_tvalid && m_tuser == EV_START,
        m_tdata[0] && m_tdata[16:1] == 16'd0 && m_tdata[32:17] == 16'd1)

endmodule

bind speech_endpoint_detector sed_checker u_sed_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/endpoint_checker.sv @@
`timescale 1ns / 100ps
// Checker for speech_endpoint_detector: tracks register writes, predicts one
// result per input transfer and compares result transfers in order.
// Depends on sed_pkg.
module endpoint_checker
    import sed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          fail_count
);

    sed_cfg_t         cfg;
    logic             armed;
    logic             speech_seen;
    logic [CNT_W-1:0] silence_cnt;
    logic [CNT_W-1:0] voiced_cnt;
    logic [CNT_W-1:0] frame_cnt;
    sed_result_t      expected_results[$];
    int               mismatches = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic sed_result_t advance_session(input logic cmd, input logic [7:0] score);
        sed_result_t r;
        logic        voiced;
        r.event_res = EV_LISTEN;
        if (cmd == CMD_ARM)
        begin
            if (!armed)
            begin
                speech_seen = 1'b0;
                silence_cnt = '0;
                voiced_cnt  = '0;
                frame_cnt   = '0;
                armed       = 1'b1;
            end
        end
        else if (!armed)
        begin
            r.event_res = EV_IDLE;
        end
        else
        begin
            voiced    = (score >= cfg.voice_threshold);
            frame_cnt = bump(frame_cnt);
            if (!speech_seen)
            begin
                if (voiced)
                begin
                    speech_seen = 1'b1;
                    voiced_cnt  = bump(voiced_cnt);
                    r.event_res = EV_START;
                end
                else if (frame_cnt >= cfg.max_frames)
                begin
                    silence_cnt = cfg.quiet_frames;
                end
            end
            else
            begin
                if (voiced)
                begin
                    silence_cnt = '0;
                    voiced_cnt  = bump(voiced_cnt);
                end
                else
                begin
                    silence_cnt = bump(silence_cnt);
                end
                if (frame_cnt >= cfg.max_frames && silence_cnt < cfg.quiet_frames)
                    silence_cnt = cfg.quiet_frames;
            end
            // end of utterance outranks speech start
            if (silence_cnt >= cfg.quiet_frames)
            begin
                if (speech_seen && voiced_cnt < cfg.min_voiced)
                begin
                    silence_cnt = '0;
                    voiced_cnt  = '0;
                    speech_seen = 1'b0;
                    r.event_res = EV_REJECT;
                end
                else
                begin
                    armed       = 1'b0;
                    r.event_res = EV_ACCEPT;
                end
            end
        end
        r.speech_active = speech_seen;
        r.silence_run   = silence_cnt;
        r.voiced_total  = voiced_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sed_result_t want;
        if (!rst_n)
        begin
            cfg.voice_threshold = RST_VOICE_THRESHOLD;
            cfg.quiet_frames    = RST_QUIET_FRAMES;
            cfg.max_frames      = RST_MAX_FRAMES;
            cfg.min_voiced      = RST_MIN_VOICED;
            armed               = 1'b0;
            speech_seen         = 1'b0;
            silence_cnt         = '0;
            voiced_cnt          = '0;
            frame_cnt           = '0;
            expected_results.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no result expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("event_res", want.event_res, m_tuser);
                    check_field("speech_active", want.speech_active, m_tdata[0]);
                    check_field("silence_run", want.silence_run, m_tdata[16:1]);
                    check_field("voiced_total", want.voiced_total, m_tdata[32:17]);
                    check_field("tdata padding", 0, m_tdata[39:33]);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                                        advance_session(s_tuser, s_tdata));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_VOICE_THRESHOLD: cfg.voice_threshold = pwdata[THR_W-1:0];
                    REG_QUIET_FRAMES:    cfg.quiet_frames    = pwdata[CNT_W-1:0];
                    REG_MAX_FRAMES:      cfg.max_frames      = pwdata[CNT_W-1:0];
                    REG_MIN_VOICED:      cfg.min_voiced      = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            pending    <= expected_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the speech_endpoint_detector testbench: clock, reset, stream and
// register stimulus, verdict. Depends on sed_pkg, speech_endpoint_detector and endpoint_checker.
module tb;
    import sed_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 45;
    localparam int BUDGET_RUN  = 42;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int               pending;
    int               fail_count;
    int               cycle_count = 0;
    bit               no_idle     = 1'b0;
    bit               long_hold   = 1'b0;
    logic [THR_W-1:0] cur_thr     = RST_VOICE_THRESHOLD;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    speech_endpoint_detector u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    endpoint_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("speech_endpoint_detector regression: fail");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [7:0] pick_score(input bit voiced);
        if (voiced)
            return 8'($urandom_range(cur_thr, 255));
        else if (cur_thr == 0)
            return 8'($urandom_range(0, 255));
        else
            return 8'($urandom_range(0, cur_thr - 1));
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] score);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= score;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // leaves psel high so writes can run back to back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic configure(input logic [7:0] thr, input logic [15:0] quiet,
                             input logic [15:0] maxf, input logic [15:0] minv);
        wait_drained();
        write_reg(REG_VOICE_THRESHOLD, 32'(thr));
        write_reg(REG_QUIET_FRAMES, 32'(quiet));
        write_reg(REG_MAX_FRAMES, 32'(maxf));
        write_reg(REG_MIN_VOICED, 32'(minv));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_thr = thr;
    endtask

    // mostly arm-then-frames sessions, some stray arms and raw scores
    task automatic run_sessions(input int quota);
        int sent;
        int frames;
        int p_voice;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom));
                sent++;
            end
            else
            begin
                send_item(CMD_ARM, 8'($urandom));
                sent++;
                p_voice = $urandom_range(5, 95);
                frames  = $urandom_range(1, 30);
                repeat (frames)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(CMD_ARM, 8'($urandom));
                    else if ($urandom_range(0, 9) == 0)
                        send_item(CMD_FRAME, 8'($urandom));
                    else
                        send_item(CMD_FRAME, pick_score($urandom_range(0, 99) < p_voice));
                    sent++;
                end
            end
        end
    endtask

    // result side
    initial
    begin
        int gap;
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                gap = LONG_HOLD;
            end
            else
            begin
                gap = idle_cycles();
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int ph;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // frames while idle, arm, arm again, silent then threshold-equal score
        send_item(CMD_FRAME, 8'd0);
        send_item(CMD_FRAME, 8'd255);
        send_item(CMD_ARM, 8'd0);
        send_item(CMD_ARM, 8'd255);
        send_item(CMD_FRAME, 8'd127);
        send_item(CMD_FRAME, 8'd128);
        // too few voiced frames: rejected, then a new utterance accepted
        configure(8'd128, 16'd2, 16'd12, 16'd3);
        send_item(CMD_FRAME, 8'd0);
        send_item(CMD_FRAME, 8'd200);
        send_item(CMD_FRAME, 8'd0);
        send_item(CMD_FRAME, 8'd0);
        send_item(CMD_FRAME, 8'd130);
        send_item(CMD_FRAME, 8'd131);
        send_item(CMD_FRAME, 8'd255);
        send_item(CMD_FRAME, 8'd0);
        send_item(CMD_FRAME, 8'd0);
        send_item(CMD_FRAME, 8'd77);
        // budget runs out with no speech
        configure(8'd128, 16'd2, 16'd3, 16'd3);
        send_item(CMD_ARM, 8'd0);
        send_item(CMD_FRAME, 8'd5);
        send_item(CMD_FRAME, 8'd5);
        send_item(CMD_FRAME, 8'd5);
        // zero quiet limit: end event beats speech start
        configure(8'd128, 16'd0, 16'd3, 16'd5);
        send_item(CMD_ARM, 8'd0);
        send_item(CMD_FRAME, 8'd255);
        send_item(CMD_FRAME, 8'd0);
        // zero frame budget
        configure(8'd128, 16'd5, 16'd0, 16'd5);
        send_item(CMD_ARM, 8'd0);
        send_item(CMD_FRAME, 8'd128);
        send_item(CMD_FRAME, 8'd0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            no_idle = (ph % 3 == 1);
            case (ph)
                0: configure(8'd0, 16'd1, 16'd1, 16'd0);
                1: configure(8'd255, 16'hFFFF, 16'($urandom_range(5, 30)), 16'hFFFF);
                default: configure(8'($urandom_range(40, 220)), 16'($urandom_range(1, 8)),
                                   16'($urandom_range(1, 60)), 16'($urandom_range(0, 6)));
            endcase
            if (ph == 2)
                long_hold = 1'b1;
            run_sessions(PHASE_ITEMS);
        end

        // frame budget ends a session after speech: reject, then accept
        no_idle = 1'b1;
        configure(8'd255, 16'hFFFF, 16'd40, 16'hFFFF);
        send_item(CMD_ARM, 8'd0);
        for (int i = 0; i < BUDGET_RUN; i++)
            send_item(CMD_FRAME, (i == 5) ? 8'd255 : 8'($urandom_range(0, 254)));

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("speech_endpoint_detector regression: pass");
        else
            $display("speech_endpoint_detector regression: fail");
        $finish;
    end

endmodule
